>>> design/twac_pkg.sv
// ----------------------------------------------------------------------------
// twac_pkg
// Shared types, codes and constants of the thermostat window actuator control.
// ----------------------------------------------------------------------------
package twac_pkg;

  localparam int TempW   = 11;
  localparam int ThreshW = 9;
  localparam int OffsetW = 8;
  localparam int PulseW  = 12;
  localparam int CfgW    = 9;

  localparam logic [PulseW-1:0] PulseUp   = 12'd500;
  localparam logic [PulseW-1:0] PulseStop = 12'd1500;
  localparam logic [PulseW-1:0] PulseDown = 12'd2500;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_TICK   = 2'd1,
    OP_MANUAL = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    DIR_UP   = 2'd0,
    DIR_STOP = 2'd1,
    DIR_DOWN = 2'd2,
    DIR_NONE = 2'd3
  } dir_t;

  typedef enum logic [1:0] {
    POS_CLOSED = 2'd0,
    POS_PARTLY = 2'd1,
    POS_FULL   = 2'd2
  } pos_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_OPEN  = 2'd1,
    PH_CLOSE = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    REG_OPEN_THRESHOLD  = 2'd0,
    REG_CLOSE_THRESHOLD = 2'd1,
    REG_TEMP_OFFSET     = 2'd2,
    REG_UNUSED          = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [ThreshW-1:0]        open_threshold;
    logic [ThreshW-1:0]        close_threshold;
    logic signed [OffsetW-1:0] temp_offset;
  } cfg_t;

  typedef struct packed {
    phase_t                  move_phase;
    logic [PulseW-1:0]       drive_pulse;
    logic signed [TempW-1:0] last_temp;
  } state_t;

endpackage

>>> design/twac_cfg.sv
// ----------------------------------------------------------------------------
// twac_cfg
// Configuration register file: thresholds and temperature offset.
// ----------------------------------------------------------------------------
module twac_cfg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [twac_pkg::CfgW-1:0] cfg_data,
  output twac_pkg::cfg_t            cfg
);
  import twac_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.open_threshold  <= ThreshW'(250);
      cfg.close_threshold <= ThreshW'(220);
      cfg.temp_offset     <= -OffsetW'(15);
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_index_t'(cfg_index))
        REG_OPEN_THRESHOLD:  cfg.open_threshold  <= cfg_data[ThreshW-1:0];
        REG_CLOSE_THRESHOLD: cfg.close_threshold <= cfg_data[ThreshW-1:0];
        REG_TEMP_OFFSET:     cfg.temp_offset     <= cfg_data[OffsetW-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> design/twac_step.sv
// ----------------------------------------------------------------------------
// twac_step
// Update logic for one request: position decode, offset correction with
// saturation, threshold compare, stop check and manual drive.
// ----------------------------------------------------------------------------
module twac_step (
  input  twac_pkg::cfg_t                  cfg,
  input  twac_pkg::state_t                state,
  input  logic [1:0]                      op,
  input  logic signed [twac_pkg::TempW-1:0] sensor_temp,
  input  logic                            upper_switch,
  input  logic                            lower_switch,
  input  logic [1:0]                      manual_dir,
  output twac_pkg::state_t                state_next,
  output twac_pkg::pos_t                  pos
);
  import twac_pkg::*;

  logic signed [TempW:0]   sum;
  logic signed [TempW-1:0] temp_sat;
  logic signed [TempW:0]   temp_ext;
  logic signed [TempW:0]   open_ext;
  logic signed [TempW:0]   close_ext;

  always_comb begin
    priority if (!upper_switch && !lower_switch) begin
      pos = POS_FULL;
    end else if (upper_switch && !lower_switch) begin
      pos = POS_PARTLY;
    end else begin
      pos = POS_CLOSED;
    end
  end

  assign sum = (TempW+1)'(sensor_temp) + (TempW+1)'(cfg.temp_offset);

  always_comb begin
    priority if (sum > (TempW+1)'(1023)) begin
      temp_sat = TempW'(1023);
    end else if (sum < -(TempW+1)'(1024)) begin
      temp_sat = -TempW'(1024);
    end else begin
      temp_sat = sum[TempW-1:0];
    end
  end

  assign temp_ext  = (TempW+1)'(temp_sat);
  assign open_ext  = signed'({3'b000, cfg.open_threshold});
  assign close_ext = signed'({3'b000, cfg.close_threshold});

  always_comb begin
    state_next = state;
    unique case (op_t'(op))
      OP_SAMPLE: begin
        state_next.last_temp = temp_sat;
        priority if (temp_ext >= open_ext) begin
          if (state.move_phase == PH_IDLE && pos != POS_FULL) begin
            state_next.move_phase  = PH_OPEN;
            state_next.drive_pulse = PulseUp;
          end
        end else if (temp_ext < close_ext) begin
          if (state.move_phase == PH_IDLE && pos != POS_CLOSED) begin
            state_next.move_phase  = PH_CLOSE;
            state_next.drive_pulse = PulseDown;
          end
        end
      end
      OP_TICK: begin
        if ((state.move_phase == PH_OPEN && !upper_switch && !lower_switch) ||
            (state.move_phase == PH_CLOSE && upper_switch && lower_switch)) begin
          state_next.move_phase  = PH_IDLE;
          state_next.drive_pulse = PulseStop;
        end
      end
      OP_MANUAL: begin
        unique case (dir_t'(manual_dir))
          DIR_UP:   state_next.drive_pulse = PulseUp;
          DIR_STOP: state_next.drive_pulse = PulseStop;
          DIR_DOWN: state_next.drive_pulse = PulseDown;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

endmodule

>>> design/thermostat_window_actuator_control.sv
// ----------------------------------------------------------------------------
// thermostat_window_actuator_control
// Two-point thermostat driving a window actuator between two limit switches.
// ----------------------------------------------------------------------------
// Requests arrive on the input channel (in_valid, in_stall): a temperature
// sample, a stop-check tick or a manual drive command, each carrying both
// limit switch levels. Every request yields exactly one result on the output
// channel (out_valid, out_stall): drive pulse, move state, window position
// and the last corrected temperature, taken after the update.
// A request is captured in an input register and is then applied to the
// state, where the state registers themselves form the result register.
// One request is taken every cycle while the receiver does not stall.
// While the receiver stalls, the held result and the request behind it stay
// in place and in_stall rises; nothing is lost or repeated.
// Thresholds and the offset are written on the always ready cfg channel; the
// user must write it only while no request is in flight; no logic enforces it.
// Reset clears both pipeline valids, sets the phase to idle, the pulse to
// stop and the stored temperature to zero, and loads the register defaults.
// ----------------------------------------------------------------------------
module thermostat_window_actuator_control (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         op,
  input  logic signed [twac_pkg::TempW-1:0]  sensor_temp,
  input  logic                               upper_switch,
  input  logic                               lower_switch,
  input  logic [1:0]                         manual_dir,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [twac_pkg::PulseW-1:0]        servo_pulse_us,
  output logic [1:0]                         move_state,
  output logic [1:0]                         window_position,
  output logic signed [twac_pkg::TempW-1:0]  corrected_temp,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [1:0]                         cfg_index,
  input  logic [twac_pkg::CfgW-1:0]          cfg_data
);
  import twac_pkg::*;

  cfg_t   cfg;
  state_t state;
  state_t state_next;
  pos_t   pos_next;
  pos_t   pos;

  logic                    req_valid;
  logic [1:0]              req_op;
  logic signed [TempW-1:0] req_temp;
  logic                    req_upper;
  logic                    req_lower;
  logic [1:0]              req_dir;
  logic                    advance;

  twac_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  twac_step u_step (
    .cfg          (cfg),
    .state        (state),
    .op           (req_op),
    .sensor_temp  (req_temp),
    .upper_switch (req_upper),
    .lower_switch (req_lower),
    .manual_dir   (req_dir),
    .state_next   (state_next),
    .pos          (pos_next)
  );

  assign advance  = req_valid && (!out_valid || !out_stall);
  assign in_stall = req_valid && out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!in_stall) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      req_op    <= op;
      req_temp  <= sensor_temp;
      req_upper <= upper_switch;
      req_lower <= lower_switch;
      req_dir   <= manual_dir;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid         <= 1'b0;
      state.move_phase  <= PH_IDLE;
      state.drive_pulse <= PulseStop;
      state.last_temp   <= '0;
    end else if (advance) begin
      out_valid <= 1'b1;
      state     <= state_next;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pos <= pos_next;
    end
  end

  assign servo_pulse_us  = state.drive_pulse;
  assign move_state      = state.move_phase;
  assign window_position = pos;
  assign corrected_temp  = state.last_temp;

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the thermostat window actuator control.
// Requests go in with random gaps and results are taken under random output
// stall. A predictor of the drive pulse, move state, window position and
// corrected temperature keeps a queue of expected results. The run starts
// with directed requests at the default thresholds and then goes through
// several threshold and offset settings, the extremes among them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import twac_pkg::*;

  typedef struct packed {
    logic [PulseW-1:0] pulse;
    logic [1:0]        phase;
    logic [1:0]        pos;
    logic [TempW-1:0]  temp;
  } status_t;

  class actuator_check;
    logic [ThreshW-1:0]        open_th;
    logic [ThreshW-1:0]        close_th;
    logic signed [OffsetW-1:0] offset;
    phase_t                    phase;
    logic [PulseW-1:0]         pulse;
    logic signed [TempW-1:0]   temp;
    status_t                   expected_status[$];
    int                        errors;

    function new();
      open_th  = 9'd250;
      close_th = 9'd220;
      offset   = -8'sd15;
      phase    = PH_IDLE;
      pulse    = PulseStop;
      temp     = '0;
      errors   = 0;
    endfunction

    function void configure(reg_index_t idx, logic [CfgW-1:0] data);
      case (idx)
        REG_OPEN_THRESHOLD: open_th = data[ThreshW-1:0];
        REG_CLOSE_THRESHOLD: close_th = data[ThreshW-1:0];
        REG_TEMP_OFFSET: offset = data[OffsetW-1:0];
        default: ;
      endcase
    endfunction

    function void note_request(op_t code, logic signed [TempW-1:0] raw, logic up,
                               logic low, dir_t dir);
      int      t;
      pos_t    pos;
      status_t s;
      if (!up && !low) begin
        pos = POS_FULL;
      end else if (up && !low) begin
        pos = POS_PARTLY;
      end else begin
        pos = POS_CLOSED;
      end
      case (code)
        OP_SAMPLE: begin
          t = int'(raw) + int'(offset);
          if (t > 1023) t = 1023;
          if (t < -1024) t = -1024;
          temp = t[TempW-1:0];
          if (t >= int'(open_th)) begin
            if (phase == PH_IDLE && pos != POS_FULL) begin
              phase = PH_OPEN;
              pulse = PulseUp;
            end
          end else if (t < int'(close_th)) begin
            if (phase == PH_IDLE && pos != POS_CLOSED) begin
              phase = PH_CLOSE;
              pulse = PulseDown;
            end
          end
        end
        OP_TICK: begin
          if ((phase == PH_OPEN && !up && !low) || (phase == PH_CLOSE && up && low)) begin
            phase = PH_IDLE;
            pulse = PulseStop;
          end
        end
        OP_MANUAL: begin
          case (dir)
            DIR_UP: pulse = PulseUp;
            DIR_STOP: pulse = PulseStop;
            DIR_DOWN: pulse = PulseDown;
            default: ;
          endcase
        end
        default: ;
      endcase
      s.pulse = pulse;
      s.phase = phase;
      s.pos   = pos;
      s.temp  = temp;
      expected_status.push_back(s);
    endfunction

    function void field_check(string field, int want, int got);
      if (want != got) begin
        $display("%0t tb: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_status(logic [PulseW-1:0] pulse_got, logic [1:0] phase_got,
                               logic [1:0] pos_got, logic signed [TempW-1:0] temp_got);
      status_t want;
      if (expected_status.size() == 0) begin
        $display("%0t tb: result with no request waiting, expected none, actual pulse %0d",
                 $time, pulse_got);
        errors++;
        return;
      end
      want = expected_status.pop_front();
      field_check("servo_pulse_us", want.pulse, pulse_got);
      field_check("move_state", want.phase, phase_got);
      field_check("window_position", want.pos, pos_got);
      field_check("corrected_temp", $signed(want.temp), temp_got);
    endfunction

    function int pending();
      return expected_status.size();
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [1:0]                op = OP_NONE;
  logic signed [TempW-1:0]   sensor_temp = '0;
  logic                      upper_switch = 1'b0;
  logic                      lower_switch = 1'b0;
  logic [1:0]                manual_dir = DIR_STOP;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [PulseW-1:0]         servo_pulse_us;
  logic [1:0]                move_state;
  logic [1:0]                window_position;
  logic signed [TempW-1:0]   corrected_temp;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [1:0]                cfg_index = REG_UNUSED;
  logic [CfgW-1:0]           cfg_data = '0;

  actuator_check sb;
  bit            sender_steady = 1'b0;
  bit            receiver_steady = 1'b0;
  bit            long_hold_req = 1'b0;
  int            hold_left = 0;
  int            stall_left = 0;

  thermostat_window_actuator_control dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .op             (op),
    .sensor_temp    (sensor_temp),
    .upper_switch   (upper_switch),
    .lower_switch   (lower_switch),
    .manual_dir     (manual_dir),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .servo_pulse_us (servo_pulse_us),
    .move_state     (move_state),
    .window_position(window_position),
    .corrected_temp (corrected_temp),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall)
        sb.check_status(servo_pulse_us, move_state, window_position, corrected_temp);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!receiver_steady && $urandom_range(0, 99) < 20) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 29) : $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (sender_steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int pick_temp();
    int r;
    int th;
    r = $urandom_range(0, 99);
    if (r < 60) return int'($urandom_range(0, 1200)) - 400;
    if (r < 85) begin
      th = $urandom_range(0, 1) ? int'(sb.open_th) : int'(sb.close_th);
      return th - int'(sb.offset) + int'($urandom_range(0, 6)) - 3;
    end
    if (r < 95) return int'($urandom_range(0, 2047)) - 1024;
    return $urandom_range(0, 1) ? 1023 : -1024;
  endfunction

  task automatic send_request(op_t code, int raw, logic up, logic low, dir_t dir);
    int gap;
    in_valid     <= 1'b1;
    op           <= code;
    sensor_temp  <= raw[TempW-1:0];
    upper_switch <= up;
    lower_switch <= low;
    manual_dir   <= dir;
    do @(posedge clk); while (in_stall);
    sb.note_request(code, raw[TempW-1:0], up, low, dir);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random();
    int r;
    op_t code;
    r = $urandom_range(0, 99);
    if (r < 40) code = OP_SAMPLE;
    else if (r < 75) code = OP_TICK;
    else if (r < 92) code = OP_MANUAL;
    else code = OP_NONE;
    send_request(code, pick_temp(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 dir_t'($urandom_range(0, 3)));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CfgW-1:0];
    do @(posedge clk); while (!cfg_ready);
    sb.configure(idx, value[CfgW-1:0]);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_thresholds(int open_v, int close_v, int offset_v);
    write_reg(REG_OPEN_THRESHOLD, open_v);
    write_reg(REG_CLOSE_THRESHOLD, close_v);
    write_reg(REG_TEMP_OFFSET, offset_v);
  endtask

  initial begin
    int p;
    int n;
    int open_v;
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Default thresholds: open at 250, close below 220, offset -15.
    send_request(OP_NONE, 0, 1'b0, 1'b0, DIR_UP);
    send_request(OP_SAMPLE, 1023, 1'b1, 1'b1, DIR_NONE);
    send_request(OP_TICK, 0, 1'b1, 1'b1, DIR_UP);
    send_request(OP_SAMPLE, 1023, 1'b0, 1'b1, DIR_STOP);
    send_request(OP_TICK, 0, 1'b0, 1'b0, DIR_STOP);
    send_request(OP_SAMPLE, 800, 1'b0, 1'b0, DIR_STOP);
    send_request(OP_SAMPLE, 800, 1'b1, 1'b0, DIR_STOP);
    send_request(OP_TICK, 0, 1'b0, 1'b0, DIR_STOP);
    send_request(OP_SAMPLE, -1024, 1'b0, 1'b0, DIR_STOP);
    send_request(OP_TICK, 0, 1'b1, 1'b0, DIR_STOP);
    send_request(OP_TICK, 0, 1'b1, 1'b1, DIR_STOP);
    send_request(OP_SAMPLE, -400, 1'b0, 1'b1, DIR_STOP);
    send_request(OP_SAMPLE, 235, 1'b1, 1'b0, DIR_STOP);
    send_request(OP_SAMPLE, 265, 1'b1, 1'b0, DIR_STOP);
    send_request(OP_MANUAL, 0, 1'b1, 1'b0, DIR_STOP);
    send_request(OP_MANUAL, 0, 1'b1, 1'b0, DIR_NONE);
    send_request(OP_MANUAL, 0, 1'b1, 1'b0, DIR_DOWN);
    send_request(OP_MANUAL, 0, 1'b1, 1'b0, DIR_UP);
    send_request(OP_TICK, 0, 1'b0, 1'b0, DIR_STOP);
    send_request(OP_SAMPLE, 234, 1'b1, 1'b0, DIR_STOP);
    send_request(OP_TICK, 0, 1'b0, 1'b1, DIR_STOP);
    send_request(OP_NONE, -1, 1'b1, 1'b1, DIR_NONE);
    send_request(OP_TICK, 0, 1'b1, 1'b1, DIR_STOP);

    for (p = 0; p < 8; p++) begin
      drain();
      case (p)
        0: set_thresholds(500, 100, 100);
        1: set_thresholds(100, 500, -100);
        default: begin
          if (p == 2) write_reg(REG_UNUSED, $urandom_range(0, 511));
          open_v = $urandom_range(100, 500);
          set_thresholds(open_v, $urandom_range(100, 500), int'($urandom_range(0, 200)) - 100);
        end
      endcase
      sender_steady   = (p == 3 || p == 4);
      receiver_steady = (p == 3);
      // The receiver holds off for a long stretch while requests keep coming.
      if (p == 4) long_hold_req = 1'b1;
      for (n = 0; n < 210; n++) begin
        // The sender waits until every result is in before going on.
        if (p == 5 && n == 105) drain();
        send_random();
      end
    end
    sender_steady   = 1'b0;
    receiver_steady = 1'b0;

    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
